// File: hdl/cgl_pkg.sv
// types, constants and helper functions shared by the colour gradient blocks
`default_nettype none

package cgl_pkg;

  // gradient stop store
  localparam int unsigned MAX_STOPS = 7;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned WORD_W    = 48;
  localparam int unsigned COLOR_W   = 32;
  localparam int unsigned POS_LSB   = 32;

  // sample and fraction widths
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned FRAC_W    = 16;
  localparam logic [FRAC_W:0] F_ONE = {1'b1, {FRAC_W{1'b0}}};

  // colour channels, alpha first (msb) down to red (lsb)
  localparam int unsigned CH_W      = 8;
  localparam int unsigned NUM_CH    = 4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_WORD_0 = 3'd1;

  // divider pipeline: quotient bits resolved per stage
  localparam int unsigned DIV_STEP   = 2;
  localparam int unsigned DIV_STAGES = FRAC_W / DIV_STEP;

  typedef enum logic [1:0] {
    FRAC_ZERO,
    FRAC_ONE,
    FRAC_DIV
  } frac_e;

  // what travels alongside the divider
  typedef struct packed {
    logic               empty;
    frac_e              frac;
    logic [COLOR_W-1:0] c1;
    logic [COLOR_W-1:0] c2;
  } cgl_tag_t;

  typedef struct packed {
    logic [POS_W-1:0]  rem;
    logic [FRAC_W-1:0] quo;
  } div_st_t;

  // one restoring division step, remainder kept below the divisor
  function automatic div_st_t div_step(div_st_t st, logic [POS_W-1:0] den);
    logic [POS_W:0] r2;
    div_st_t        res;
    r2 = {st.rem, 1'b0};
    if (r2 >= {1'b0, den}) begin
      res.rem = POS_W'(r2 - {1'b0, den});
      res.quo = {st.quo[FRAC_W-2:0], 1'b1};
    end else begin
      res.rem = r2[POS_W-1:0];
      res.quo = {st.quo[FRAC_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hdl/cgl_div.sv
// pipelined restoring divider for the interpolation fraction
`default_nettype none

module cgl_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cgl_pkg::cgl_tag_t             in_tag_i,
  input  logic [cgl_pkg::POS_W-1:0]     in_num_i,
  input  logic [cgl_pkg::POS_W-1:0]     in_den_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cgl_pkg::cgl_tag_t             out_tag_o,
  output logic [cgl_pkg::FRAC_W-1:0]    out_quo_o
);

  localparam int unsigned NS = cgl_pkg::DIV_STAGES;

  logic [NS-1:0]                v_q;
  logic [NS:0]                  adv;
  cgl_pkg::cgl_tag_t            tag_q [NS];
  logic [cgl_pkg::POS_W-1:0]    den_q [NS];
  cgl_pkg::div_st_t             st_q  [NS];

  logic [NS-1:0]                src_valid;
  cgl_pkg::cgl_tag_t            src_tag [NS];
  logic [cgl_pkg::POS_W-1:0]    src_den [NS];
  cgl_pkg::div_st_t             st_d    [NS];

  // a stage takes new data when empty or when its content moves on
  always_comb begin
    adv[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_comb begin
    cgl_pkg::div_st_t st;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        src_valid[k] = in_valid_i;
        src_tag[k]   = in_tag_i;
        src_den[k]   = in_den_i;
        st.rem       = in_num_i;
        st.quo       = '0;
      end else begin
        src_valid[k] = v_q[k-1];
        src_tag[k]   = tag_q[k-1];
        src_den[k]   = den_q[k-1];
        st           = st_q[k-1];
      end
      for (int j = 0; j < cgl_pkg::DIV_STEP; j++) begin
        st = cgl_pkg::div_step(st, src_den[k]);
      end
      st_d[k] = st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= src_valid[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (adv[k] && src_valid[k]) begin
        tag_q[k] <= src_tag[k];
        den_q[k] <= src_den[k];
        st_q[k]  <= st_d[k];
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NS-1];
  assign out_tag_o   = tag_q[NS-1];
  assign out_quo_o   = st_q[NS-1].quo;

endmodule

`default_nettype wire

// File: hdl/color_gradient_lerp.sv
// top level of the piecewise linear argb colour gradient
`default_nettype none

// Maps a 16-bit sample position to an argb colour through up to seven gradient
// stops. Each stop word holds the stop position in bits 47..32 and the colour
// in bits 31..0 (alpha, blue, green, red from msb down). The first stop whose
// successor lies strictly above the position is taken and every channel is
// blended as c1 + (c2 - c1) * f, with f the q1.16 fraction of the way between
// the two stop positions. A position at or past the last stop, or a single
// stop, gives that stop's colour; an empty list gives zero. One item enters
// per cycle while input ready is high. The stages, in order, are one for the
// stop search, one for the distances, eight for the divider that resolves
// two fraction bits per stage, one for the channel multiplies and one for
// the final add. Each stage holds its item until the next one is free, so a
// stall at the output fills the pipeline before input ready drops.
// The configuration port is always ready; write it only while no item is in
// flight, as stop data is sampled when an item enters.

module color_gradient_lerp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // sample channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [cgl_pkg::SAMPLE_W-1:0]    sample_position_i,
  // colour channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [cgl_pkg::CH_W-1:0]        alpha_out_o,
  output logic [cgl_pkg::CH_W-1:0]        blue_out_o,
  output logic [cgl_pkg::CH_W-1:0]        green_out_o,
  output logic [cgl_pkg::CH_W-1:0]        red_out_o,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cgl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [cgl_pkg::WORD_W-1:0]      cfg_data_i
);

  localparam int unsigned POS_W   = cgl_pkg::POS_W;
  localparam int unsigned COLOR_W = cgl_pkg::COLOR_W;
  localparam int unsigned CH_W    = cgl_pkg::CH_W;
  localparam int unsigned NUM_CH  = cgl_pkg::NUM_CH;
  localparam int unsigned FRAC_W  = cgl_pkg::FRAC_W;
  localparam int unsigned PROD_W  = CH_W + FRAC_W + 1;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [cgl_pkg::CNT_W-1:0]  stop_count_q;
  logic [cgl_pkg::WORD_W-1:0] stop_word_q [cgl_pkg::MAX_STOPS];
  logic [cgl_pkg::CFG_IDX_W-1:0] word_idx;

  assign cfg_ready_o = 1'b1;
  assign word_idx    = cfg_index_i - cgl_pkg::REG_STOP_WORD_0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_count_q <= '0;
      for (int i = 0; i < cgl_pkg::MAX_STOPS; i++) begin
        stop_word_q[i] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == cgl_pkg::REG_STOP_COUNT) begin
        stop_count_q <= cfg_data_i[cgl_pkg::CNT_W-1:0];
      end else begin
        // indexes past the stop words are dropped
        for (int i = 0; i < cgl_pkg::MAX_STOPS; i++) begin
          if (cfg_index_i >= cgl_pkg::REG_STOP_WORD_0 &&
              word_idx == cgl_pkg::CFG_IDX_W'(i)) begin
            stop_word_q[i] <= cfg_data_i;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // handshake chain, each stage advances when empty or when drained
  // ---------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, m_v_q, o_v_q;
  logic s1_adv, s2_adv, m_adv, o_adv;
  logic div_in_ready, div_out_valid;

  assign o_adv  = !o_v_q  || out_ready_i;
  assign m_adv  = !m_v_q  || o_adv;
  assign s2_adv = !s2_v_q || div_in_ready;
  assign s1_adv = !s1_v_q || s2_adv;
  assign in_ready_o = s1_adv;

  // ---------------------------------------------------------------------------
  // stage 1: stop search, all stop positions compared in parallel
  // ---------------------------------------------------------------------------
  logic [cgl_pkg::CNT_W-1:0] cnt;
  logic [POS_W-1:0]          in_pos;
  logic                      sel_empty, sel_interp;
  logic [POS_W-1:0]          sel_p1, sel_p2;
  logic [COLOR_W-1:0]        sel_c1, sel_c2;

  logic                      s1_empty_q, s1_interp_q;
  logic [POS_W-1:0]          s1_pos_q, s1_p1_q, s1_p2_q;
  logic [COLOR_W-1:0]        s1_c1_q, s1_c2_q;

  assign in_pos = sample_position_i[POS_W-1:0];

  always_comb begin
    cnt = (stop_count_q > cgl_pkg::CNT_W'(cgl_pkg::MAX_STOPS)) ?
          cgl_pkg::CNT_W'(cgl_pkg::MAX_STOPS) : stop_count_q;
    sel_empty  = (cnt == '0);
    sel_interp = 1'b0;
    sel_p1     = '0;
    sel_p2     = '0;
    sel_c1     = '0;
    sel_c2     = '0;
    // fall back to the last stop in use
    for (int i = 0; i < cgl_pkg::MAX_STOPS; i++) begin
      if (cgl_pkg::CNT_W'(i + 1) == cnt) begin
        sel_c1 = stop_word_q[i][COLOR_W-1:0];
        sel_c2 = stop_word_q[i][COLOR_W-1:0];
      end
    end
    // lowest segment whose upper stop lies above the sample wins
    for (int i = cgl_pkg::MAX_STOPS - 2; i >= 0; i--) begin
      if (cgl_pkg::CNT_W'(i + 1) < cnt &&
          stop_word_q[i+1][cgl_pkg::POS_LSB +: POS_W] > in_pos) begin
        sel_interp = 1'b1;
        sel_p1     = stop_word_q[i][cgl_pkg::POS_LSB +: POS_W];
        sel_p2     = stop_word_q[i+1][cgl_pkg::POS_LSB +: POS_W];
        sel_c1     = stop_word_q[i][COLOR_W-1:0];
        sel_c2     = stop_word_q[i+1][COLOR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_adv) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      s1_empty_q  <= sel_empty;
      s1_interp_q <= sel_interp;
      s1_pos_q    <= in_pos;
      s1_p1_q     <= sel_p1;
      s1_p2_q     <= sel_p2;
      s1_c1_q     <= sel_c1;
      s1_c2_q     <= sel_c2;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: signed distances, magnitudes and fraction class
  // ---------------------------------------------------------------------------
  logic [POS_W:0]         dist_n, dist_d;
  logic [POS_W-1:0]       abs_n, abs_d;
  cgl_pkg::cgl_tag_t      tag_d;

  logic [POS_W-1:0]       s2_an_q, s2_ad_q;
  cgl_pkg::cgl_tag_t      s2_tag_q;

  always_comb begin
    dist_n = {1'b0, s1_pos_q} - {1'b0, s1_p1_q};
    dist_d = {1'b0, s1_p2_q}  - {1'b0, s1_p1_q};
    abs_n  = dist_n[POS_W] ? POS_W'(-dist_n) : dist_n[POS_W-1:0];
    abs_d  = dist_d[POS_W] ? POS_W'(-dist_d) : dist_d[POS_W-1:0];
    tag_d.empty = s1_empty_q;
    tag_d.c1    = s1_c1_q;
    tag_d.c2    = s1_c2_q;
    // no segment, zero range, zero offset or opposite signs give no blend
    if (!s1_interp_q || dist_n == '0 || dist_d == '0 ||
        dist_n[POS_W] != dist_d[POS_W]) begin
      tag_d.frac = cgl_pkg::FRAC_ZERO;
    end else if (abs_n >= abs_d) begin
      tag_d.frac = cgl_pkg::FRAC_ONE;
    end else begin
      tag_d.frac = cgl_pkg::FRAC_DIV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_adv) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_v_q) begin
      s2_an_q  <= abs_n;
      s2_ad_q  <= abs_d;
      s2_tag_q <= tag_d;
    end
  end

  // ---------------------------------------------------------------------------
  // divider: fraction = an * 2^16 / ad, only used when an < ad
  // ---------------------------------------------------------------------------
  cgl_pkg::cgl_tag_t   div_tag;
  logic [FRAC_W-1:0]   div_quo;

  cgl_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_v_q),
    .in_ready_o  (div_in_ready),
    .in_tag_i    (s2_tag_q),
    .in_num_i    (s2_an_q),
    .in_den_i    (s2_ad_q),
    .out_valid_o (div_out_valid),
    .out_ready_i (m_adv),
    .out_tag_o   (div_tag),
    .out_quo_o   (div_quo)
  );

  // ---------------------------------------------------------------------------
  // multiply stage: per channel |c2 - c1| * f, keep the integer part
  // ---------------------------------------------------------------------------
  logic [FRAC_W:0]     frac;
  logic [CH_W-1:0]     mag_d [NUM_CH];
  logic [NUM_CH-1:0]   up_d;

  logic [CH_W-1:0]     m_mag_q [NUM_CH];
  logic [NUM_CH-1:0]   m_up_q;
  logic [COLOR_W-1:0]  m_c1_q;
  logic                m_empty_q;

  always_comb begin
    case (div_tag.frac)
      cgl_pkg::FRAC_ONE: frac = cgl_pkg::F_ONE;
      cgl_pkg::FRAC_DIV: frac = {1'b0, div_quo};
      default:           frac = '0;
    endcase
  end

  always_comb begin
    logic [CH_W-1:0]   a, b, diff;
    logic [PROD_W-1:0] prod;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      a    = div_tag.c1[COLOR_W - CH_W*(ch+1) +: CH_W];
      b    = div_tag.c2[COLOR_W - CH_W*(ch+1) +: CH_W];
      up_d[ch] = (b >= a);
      diff = up_d[ch] ? b - a : a - b;
      prod = PROD_W'(diff) * PROD_W'(frac);
      mag_d[ch] = prod[FRAC_W +: CH_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (m_adv) begin
      m_v_q <= div_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_adv && div_out_valid) begin
      m_mag_q   <= mag_d;
      m_up_q    <= up_d;
      m_c1_q    <= div_tag.c1;
      m_empty_q <= div_tag.empty;
    end
  end

  // ---------------------------------------------------------------------------
  // output stage: c1 plus or minus the blended step, wrapping to 8 bits
  // ---------------------------------------------------------------------------
  logic [COLOR_W-1:0] color_d;
  logic [COLOR_W-1:0] o_color_q;

  always_comb begin
    logic [CH_W-1:0] c;
    color_d = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      c = m_c1_q[COLOR_W - CH_W*(ch+1) +: CH_W];
      color_d[COLOR_W - CH_W*(ch+1) +: CH_W] = m_up_q[ch] ? c + m_mag_q[ch]
                                                          : c - m_mag_q[ch];
    end
    if (m_empty_q) begin
      color_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (o_adv) begin
      o_v_q <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_adv && m_v_q) begin
      o_color_q <= color_d;
    end
  end

  assign out_valid_o = o_v_q;
  assign alpha_out_o = o_color_q[COLOR_W - CH_W*1 +: CH_W];
  assign blue_out_o  = o_color_q[COLOR_W - CH_W*2 +: CH_W];
  assign green_out_o = o_color_q[COLOR_W - CH_W*3 +: CH_W];
  assign red_out_o   = o_color_q[COLOR_W - CH_W*4 +: CH_W];

`ifndef SYNTHESIS
  // the divider is only trusted for a proper fraction
  a_div_proper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && s2_tag_q.frac == cgl_pkg::FRAC_DIV |-> s2_an_q < s2_ad_q)
    else $error("divider fed with numerator not below denominator");

  // an accepted item always lands in the search stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_v_q)
    else $error("accepted item lost at pipeline entry");

  // input only backs up once the front stages are full and the divider stalls
  a_no_bubble_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_v_q && s2_v_q && !div_in_ready)
    else $error("input stalled with room in the front stages");
`endif

endmodule

`default_nettype wire
